// File: sv/poll_select_link_master_macros.svh
// Assertion macros shared by the poll/select link master modules.
`ifndef POLL_SELECT_LINK_MASTER_MACROS_SVH
`define POLL_SELECT_LINK_MASTER_MACROS_SVH
`ifndef SYNTHESIS
`define PSL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define PSL_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
`define PSL_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define PSL_ASSERT(lbl, prop, msg)
`define PSL_ASSERT_IMPL(lbl, pre, post, msg)
`define PSL_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: sv/psl_pkg.sv
// Types and constants of the poll/select link master.
`timescale 1ns / 1ps
package psl_pkg;

	localparam int MaxFrame = 4096;
	localparam int LenW     = 13;
	localparam int TimerW   = 16;

	localparam logic [TimerW-1:0] TicksReset     = TimerW'(1000);
	localparam logic [LenW-1:0]   MaxLengthReset = LenW'(MaxFrame);
	localparam logic [LenW-1:0]   MinLength      = LenW'(3);

	localparam logic [7:0] ChStx     = 8'h02;
	localparam logic [7:0] ChEtx     = 8'h03;
	localparam logic [7:0] ChEot     = 8'h04;
	localparam logic [7:0] ChEnq     = 8'h05;
	localparam logic [7:0] ChAck     = 8'h06;
	localparam logic [7:0] ChNak     = 8'h15;
	localparam logic [7:0] PollBase  = 8'h40;
	localparam logic [7:0] SelBase   = 8'h60;
	localparam logic [7:0] CheckBit  = 8'h80;

	typedef enum logic [2:0] {
		CMD_POLL   = 3'd0,
		CMD_SELECT = 3'd1,
		CMD_RX     = 3'd2,
		CMD_BYTE   = 3'd3,
		CMD_TICK   = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_TX      = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_STATUS  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_NO_TRAFFIC  = 4'd1,
		ST_NAK         = 4'd2,
		ST_TIMEOUT     = 4'd3,
		ST_UNEXPECTED  = 4'd4,
		ST_MALFORMED   = 4'd5,
		ST_WRONG_SLAVE = 4'd6,
		ST_CHECK_FAIL  = 4'd7,
		ST_NO_EOT      = 4'd8,
		ST_BUSY        = 4'd9,
		ST_REFUSED     = 4'd10,
		ST_BAD_COMMAND = 4'd11
	} status_t;

	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_POLL_REPLY = 4'd1,
		PH_POLL_ADDR  = 4'd2,
		PH_POLL_BODY  = 4'd3,
		PH_POLL_CHECK = 4'd4,
		PH_POLL_EOT   = 4'd5,
		PH_SEL_REPLY  = 4'd6,
		PH_SEL_DRAIN  = 4'd7,
		PH_SEL_SEND   = 4'd8,
		PH_SEL_FINAL  = 4'd9
	} phase_t;

	typedef enum logic {
		CFG_TIMEOUT    = 1'b0,
		CFG_MAX_LENGTH = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [TimerW-1:0] timeout_ticks;
		logic [LenW-1:0]   max_length;
	} cfg_t;

	typedef struct packed {
		logic [2:0] command;
		logic [4:0] slave;
		logic [7:0] data_byte;
		logic       final_byte;
	} item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} slot_t;

	// Up to three results produced by one item; a status, if any, is the last one.
	typedef struct packed {
		logic [1:0]      count;
		slot_t [2:0]     slot;
		status_t         status;
		logic [LenW-1:0] length;
	} bundle_t;

endpackage

// File: sv/psl_core.sv
// Input register, protocol state and per-item result generation.
`timescale 1ns / 1ps
`include "poll_select_link_master_macros.svh"
module psl_core (
	input  logic             clk,
	input  logic             arst_n,
	input  psl_pkg::cfg_t    cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  psl_pkg::item_t   in_item,
	output logic             push,
	output psl_pkg::bundle_t bundle,
	input  logic             full
);
	import psl_pkg::*;

	logic              valid_s1;
	item_t             item_s1;
	logic              consume;

	phase_t            phase_q, phase_d;
	logic [4:0]        slave_q, slave_d;
	logic [7:0]        check_q, check_d;
	logic [LenW-1:0]   byte_count_q, byte_count_d;
	logic [TimerW-1:0] timer_q, timer_d;
	logic              addr_ok_q, addr_ok_d;

	logic [LenW-1:0]   lim;
	logic [TimerW-1:0] tick_lim;
	logic [TimerW-1:0] tick_val;
	logic              tick_live;
	logic              timed_out;
	logic              body_full;
	logic              cmd_full;
	logic              is_start;
	logic [7:0]        rx;
	logic [7:0]        start_addr;
	logic [7:0]        sel_addr;
	logic [7:0]        sel_check;

	function automatic bundle_t mk_status(status_t st, logic [LenW-1:0] len);
		bundle_t r;
		r = '0;
		r.count = 2'd1;
		r.slot[0] = '{kind: KIND_STATUS, data: 8'h00};
		r.status = st;
		r.length = len;
		return r;
	endfunction

	function automatic bundle_t mk_tx_status(logic [7:0] b, status_t st,
		logic [LenW-1:0] len);
		bundle_t r;
		r = '0;
		r.count = 2'd2;
		r.slot[0] = '{kind: KIND_TX, data: b};
		r.slot[1] = '{kind: KIND_STATUS, data: 8'h00};
		r.status = st;
		r.length = len;
		return r;
	endfunction

	function automatic bundle_t mk_bytes(logic [1:0] n, kind_t k0, logic [7:0] b0,
		logic [7:0] b1, logic [7:0] b2);
		bundle_t r;
		r = '0;
		r.count = n;
		r.slot[0] = '{kind: k0, data: b0};
		r.slot[1] = '{kind: KIND_TX, data: b1};
		r.slot[2] = '{kind: KIND_TX, data: b2};
		return r;
	endfunction

	// An item is retired once its results have room in the output queue.
	assign consume  = valid_s1 && ((bundle.count == 2'd0) || !full);
	assign in_ready = !valid_s1 || consume;
	assign push     = consume && (bundle.count != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			slave_q      <= '0;
			check_q      <= '0;
			byte_count_q <= '0;
			timer_q      <= '0;
			addr_ok_q    <= 1'b0;
		end else if (consume) begin
			phase_q      <= phase_d;
			slave_q      <= slave_d;
			check_q      <= check_d;
			byte_count_q <= byte_count_d;
			timer_q      <= timer_d;
			addr_ok_q    <= addr_ok_d;
		end
	end

	// Shared decode of the registered item against the current state.
	always_comb begin
		if (cfg.max_length < MinLength) begin
			lim = MinLength;
		end else if (cfg.max_length > LenW'(MaxFrame)) begin
			lim = LenW'(MaxFrame);
		end else begin
			lim = cfg.max_length;
		end
	end

	assign rx         = item_s1.data_byte;
	assign tick_lim   = (cfg.timeout_ticks == '0) ? TimerW'(1) : cfg.timeout_ticks;
	assign tick_val   = (timer_q != '1) ? timer_q + TimerW'(1) : timer_q;
	assign tick_live  = (phase_q != PH_IDLE) && (phase_q != PH_SEL_SEND);
	assign timed_out  = tick_val >= tick_lim;
	assign body_full  = ({1'b0, byte_count_q} + (LenW+1)'(2)) >= {1'b0, lim};
	assign cmd_full   = ({1'b0, byte_count_q} + (LenW+1)'(5)) >= {1'b0, lim};
	assign is_start   = (item_s1.command == CMD_POLL) || (item_s1.command == CMD_SELECT);
	assign start_addr = {3'b000, item_s1.slave} +
		((item_s1.command == CMD_POLL) ? PollBase : SelBase);
	assign sel_addr   = {3'b000, slave_q} + SelBase;
	assign sel_check  = check_q ^ rx ^ ChEtx ^ CheckBit;

	// Next state.
	always_comb begin
		phase_d      = phase_q;
		slave_d      = slave_q;
		check_d      = check_q;
		byte_count_d = byte_count_q;
		timer_d      = timer_q;
		addr_ok_d    = addr_ok_q;
		case (item_s1.command)
			CMD_POLL, CMD_SELECT: begin
				if (phase_q == PH_IDLE) begin
					slave_d      = item_s1.slave;
					timer_d      = '0;
					byte_count_d = '0;
					phase_d      = (item_s1.command == CMD_POLL) ? PH_POLL_REPLY
						: PH_SEL_REPLY;
				end
			end
			CMD_RX: begin
				timer_d = '0;
				unique case (phase_q)
					PH_POLL_REPLY: begin
						if (rx == ChStx) begin
							check_d      = '0;
							byte_count_d = '0;
							addr_ok_d    = 1'b0;
							phase_d      = PH_POLL_ADDR;
						end else begin
							phase_d = PH_IDLE;
						end
					end
					PH_POLL_ADDR: begin
						check_d = check_q ^ rx;
						if (rx == ChEtx) begin
							addr_ok_d = 1'b0;
							phase_d   = PH_POLL_CHECK;
						end else begin
							addr_ok_d = (rx == {3'b000, slave_q} + PollBase);
							phase_d   = PH_POLL_BODY;
						end
					end
					PH_POLL_BODY: begin
						if (rx == ChEtx) begin
							check_d = check_q ^ rx;
							phase_d = PH_POLL_CHECK;
						end else if (body_full) begin
							phase_d = PH_IDLE;
						end else begin
							check_d      = check_q ^ rx;
							byte_count_d = byte_count_q + LenW'(1);
						end
					end
					PH_POLL_CHECK: begin
						if (addr_ok_q && (rx == (check_q | CheckBit))) begin
							phase_d = PH_POLL_EOT;
						end else begin
							phase_d = PH_IDLE;
						end
					end
					PH_POLL_EOT: phase_d = PH_IDLE;
					PH_SEL_REPLY: begin
						if (rx == ChAck) begin
							check_d      = sel_addr;
							byte_count_d = '0;
							phase_d      = PH_SEL_SEND;
						end else if (rx == ChStx) begin
							phase_d = PH_SEL_DRAIN;
						end else begin
							phase_d = PH_IDLE;
						end
					end
					PH_SEL_DRAIN: begin
						if (rx == ChEtx) begin
							phase_d = PH_IDLE;
						end
					end
					PH_SEL_FINAL: phase_d = PH_IDLE;
					default: ;
				endcase
			end
			CMD_BYTE: begin
				if (phase_q == PH_SEL_SEND) begin
					if (cmd_full) begin
						phase_d = PH_IDLE;
					end else begin
						byte_count_d = byte_count_q + LenW'(1);
						check_d      = check_q ^ rx;
						if (item_s1.final_byte) begin
							timer_d = '0;
							phase_d = PH_SEL_FINAL;
						end
					end
				end
			end
			CMD_TICK: begin
				if (tick_live) begin
					timer_d = tick_val;
					if (timed_out) begin
						phase_d = PH_IDLE;
					end
				end
			end
			default: ;
		endcase
	end

	// Results of the item.
	always_comb begin
		bundle = '0;
		case (item_s1.command)
			CMD_POLL, CMD_SELECT: begin
				if (phase_q != PH_IDLE) begin
					bundle = mk_status(ST_BAD_COMMAND, '0);
				end else begin
					bundle = mk_bytes(2'd2, KIND_TX, ChEnq, start_addr, 8'h00);
				end
			end
			CMD_RX: begin
				unique case (phase_q)
					PH_POLL_REPLY: begin
						if (rx == ChEot) begin
							bundle = mk_status(ST_NO_TRAFFIC, '0);
						end else if (rx == ChAck) begin
							bundle = mk_status(ST_OK, '0);
						end else if (rx == ChNak) begin
							bundle = mk_status(ST_NAK, '0);
						end else if (rx != ChStx) begin
							bundle = mk_status(ST_UNEXPECTED, '0);
						end
					end
					PH_POLL_BODY: begin
						if (rx == ChEtx) begin
							bundle = '0;
						end else if (body_full) begin
							bundle = mk_tx_status(ChEot, ST_MALFORMED, byte_count_q);
						end else begin
							bundle = mk_bytes(2'd1, KIND_PAYLOAD, rx, 8'h00, 8'h00);
						end
					end
					PH_POLL_CHECK: begin
						if (!addr_ok_q) begin
							bundle = mk_tx_status(ChEot, ST_WRONG_SLAVE, byte_count_q);
						end else if (rx == (check_q | CheckBit)) begin
							bundle = mk_bytes(2'd1, KIND_TX, ChAck, 8'h00, 8'h00);
						end else begin
							bundle = mk_tx_status(ChEot, ST_CHECK_FAIL, byte_count_q);
						end
					end
					PH_POLL_EOT: begin
						bundle = mk_status((rx == ChEot) ? ST_OK : ST_NO_EOT, byte_count_q);
					end
					PH_SEL_REPLY, PH_SEL_FINAL: begin
						if (rx == ChAck) begin
							if (phase_q == PH_SEL_REPLY) begin
								bundle = mk_bytes(2'd2, KIND_TX, ChStx, sel_addr, 8'h00);
							end else begin
								bundle = mk_status(ST_OK, '0);
							end
						end else if (rx == ChNak) begin
							bundle = mk_status(ST_REFUSED, '0);
						end else if (rx == ChEot) begin
							bundle = mk_status(ST_BUSY, '0);
						end else if ((rx != ChStx) || (phase_q == PH_SEL_FINAL)) begin
							bundle = mk_status(ST_UNEXPECTED, '0);
						end
					end
					PH_SEL_DRAIN: begin
						if (rx == ChEtx) begin
							bundle = mk_status(ST_UNEXPECTED, '0);
						end
					end
					default: ;
				endcase
			end
			CMD_BYTE: begin
				if ((phase_q != PH_SEL_SEND) || cmd_full) begin
					bundle = mk_status(ST_BAD_COMMAND, '0);
				end else if (item_s1.final_byte) begin
					bundle = mk_bytes(2'd3, KIND_TX, rx, ChEtx, sel_check);
				end else begin
					bundle = mk_bytes(2'd1, KIND_TX, rx, 8'h00, 8'h00);
				end
			end
			CMD_TICK: begin
				if (tick_live && timed_out) begin
					unique case (phase_q)
						PH_POLL_REPLY: bundle = mk_status(ST_TIMEOUT, '0);
						PH_POLL_ADDR, PH_POLL_BODY, PH_POLL_CHECK:
							bundle = mk_tx_status(ChEot, ST_MALFORMED, byte_count_q);
						PH_POLL_EOT: bundle = mk_status(ST_TIMEOUT, byte_count_q);
						default: bundle = mk_status(ST_UNEXPECTED, '0);
					endcase
				end
			end
			default: ;
		endcase
	end

	`PSL_ASSERT_NEXT(a_start_enters_reply, consume && is_start && (phase_q == PH_IDLE), (phase_q == PH_POLL_REPLY) || (phase_q == PH_SEL_REPLY), "start did not enter a reply wait")
	`PSL_ASSERT(a_count_in_frame, byte_count_q < LenW'(MaxFrame), "byte count beyond frame size")
	`PSL_ASSERT_NEXT(a_stalled_item_holds, valid_s1 && !consume, valid_s1 && $stable(item_s1), "stalled item lost or changed")
	`PSL_ASSERT_IMPL(a_send_needs_room, push, !full, "results pushed into a full queue")

endmodule

// File: sv/psl_outq.sv
// Two-entry result queue that hands out the results of each item one by one.
`timescale 1ns / 1ps
`include "poll_select_link_master_macros.svh"
module psl_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  psl_pkg::bundle_t bundle,
	output logic             full,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [31:0]      m_tdata,
	output logic [1:0]       m_tuser,
	output logic             m_tlast
);
	import psl_pkg::*;

	bundle_t    q_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic [1:0] sub_q;
	bundle_t    head;
	slot_t      cur;
	logic       is_last;
	logic       xfer;
	logic       pop;
	status_t    st;
	logic [LenW-1:0] len;

	assign full     = (count_q == 2'd2);
	assign m_tvalid = (count_q != 2'd0);
	assign head     = q_q[rd_ptr_q];
	assign cur      = head.slot[sub_q];
	assign is_last  = (sub_q == head.count - 2'd1);
	assign xfer     = m_tvalid && m_tready;
	assign pop      = xfer && is_last;

	// Status and length are reported only on the status result.
	assign st      = (cur.kind == KIND_STATUS) ? head.status : ST_OK;
	assign len     = (cur.kind == KIND_STATUS) ? head.length : '0;
	assign m_tdata = {7'b0, len, st, cur.data};
	assign m_tuser = cur.kind;
	assign m_tlast = is_last;

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
			sub_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
				sub_q    <= 2'd0;
			end else if (xfer) begin
				sub_q <= sub_q + 2'd1;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`PSL_ASSERT(a_count_range, count_q != 2'd3, "result queue count out of range")
	`PSL_ASSERT_IMPL(a_sub_in_entry, m_tvalid, sub_q < head.count, "result index past its entry")
	`PSL_ASSERT_IMPL(a_push_nonempty, push, bundle.count != 2'd0, "empty entry pushed")

endmodule

// File: sv/poll_select_link_master.sv
// Top level of the poll/select link master: configuration and channel wiring.
`timescale 1ns / 1ps
// Master side of an ASCII poll/select serial link to up to 32 slaves.
// The input channel (s_*) carries one item per handshake: s_tuser is the
// command (start poll, start select, received link byte, command byte for a
// select, timer tick), s_tdata holds the slave address and the byte, and
// s_tlast marks the last command byte of a select.
// The output channel (m_*) carries results: bytes to transmit on the link,
// received payload bytes and final status words; m_tlast marks the last
// result caused by one input item. An item causes zero to three results.
// An accepted item is held in an input register and evaluated there against
// the link state; its results are registered into a two-entry queue once it
// has room, and m_tvalid is driven from that queue.
// One item is taken per cycle as long as each causes at most one result;
// otherwise the rate is set by the output port, which moves one result a
// cycle. When the receiver stalls the queue fills and s_tready drops; no
// result is lost or repeated.
// Reset puts the link idle, empties the queue and loads timeout_ticks with
// 1000 and max_length with 4096. Registers are written through cfg_*; the
// user writes them only while the block is idle; the block does not check this.
module poll_select_link_master (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // slave[4:0], data_byte[12:5], zero[15:13]
	input  logic [2:0]  s_tuser,   // command[2:0]
	input  logic        s_tlast,   // final_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // out_byte[7:0], status[11:8], length[24:12], zero
	output logic [1:0]  m_tuser,   // kind[1:0]
	output logic        m_tlast    // last
);
	import psl_pkg::*;

	cfg_t    cfg_q;
	item_t   item;
	bundle_t bundle;
	logic    push;
	logic    full;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= TicksReset;
			cfg_q.max_length    <= MaxLengthReset;
		end else if (cfg_wen) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TIMEOUT:    cfg_q.timeout_ticks <= cfg_wdata;
				CFG_MAX_LENGTH: cfg_q.max_length    <= cfg_wdata[LenW-1:0];
				default: ;
			endcase
		end
	end

	assign item.command    = s_tuser;
	assign item.slave      = s_tdata[4:0];
	assign item.data_byte  = s_tdata[12:5];
	assign item.final_byte = s_tlast;

	// Protocol engine: registered item, link state and result generation.
	psl_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (item),
		.push     (push),
		.bundle   (bundle),
		.full     (full)
	);

	// Result queue feeding the output channel one result per cycle while m_tready is high.
	psl_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.bundle   (bundle),
		.full     (full),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the poll/select link master.
`timescale 1ns / 1ps
module testbench;
	import psl_pkg::*;

	// The link protocol has three command codes that the block must ignore.
	localparam logic [2:0] CmdReserved = 3'd7;
	// An item is held in the input register and its results in the queue; this
	// pause covers items still in flight that cause no result at all.
	localparam int SettleCycles = 8;
	// Longest quiet stretch is a sender gap plus a receiver stall plus latency.
	localparam int WatchdogLimit = 2000;
	localparam int ItemsPerSetting = 36;

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic        cfg_index;
	logic [15:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // slave[4:0], data_byte[12:5], zero[15:13]
	logic [2:0]  s_tuser;   // command[2:0]
	logic        s_tlast;   // final_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // out_byte[7:0], status[11:8], length[24:12], zero
	logic [1:0]  m_tuser;   // kind[1:0]
	logic        m_tlast;   // last

	poll_select_link_master dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	typedef struct {
		kind_t       kind;
		logic [7:0]  data;
		status_t     status;
		logic [12:0] length;
		logic        last;
	} link_result_t;

	// Tracks the link state of the master the way the block should, and keeps
	// the results that each accepted item should produce, oldest first.
	class link_scoreboard;
		link_result_t awaited[$];
		link_result_t batch[$];
		int          errors;
		phase_t      phase;
		logic [4:0]  slave_q;
		logic [7:0]  check_acc;
		int          nbytes;
		int          quiet_ticks;
		bit          addr_match;
		logic [15:0] timeout_reg;
		logic [12:0] length_reg;

		function new();
			errors      = 0;
			timeout_reg = TicksReset;
			length_reg  = MaxLengthReset;
			phase       = PH_IDLE;
			slave_q     = '0;
			check_acc   = '0;
			nbytes      = 0;
			quiet_ticks = 0;
			addr_match  = 1'b0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [15:0] value);
			if (idx == CFG_TIMEOUT)
				timeout_reg = value;
			else
				length_reg = value[12:0];
		endfunction

		// Frame size limit after clamping the register to its legal range.
		function int frame_limit();
			int l;
			l = length_reg;
			if (l < 3) l = 3;
			if (l > MaxFrame) l = MaxFrame;
			return l;
		endfunction

		function int tick_limit();
			return (timeout_reg == 0) ? 1 : int'(timeout_reg);
		endfunction

		function void emit(kind_t k, logic [7:0] b, status_t st, int len);
			link_result_t r;
			r.kind   = k;
			r.data   = b;
			r.status = st;
			r.length = len[12:0];
			r.last   = 1'b0;
			batch.push_back(r);
		endfunction

		function void send_byte(logic [7:0] b);
			emit(KIND_TX, b, ST_OK, 0);
		endfunction

		function void conclude(status_t st, int len);
			emit(KIND_STATUS, 8'h00, st, len);
			phase = PH_IDLE;
		endfunction

		function void on_rx(logic [7:0] b);
			int pay;
			pay = nbytes;
			quiet_ticks = 0;
			case (phase)
			PH_POLL_REPLY: begin
				if (b == ChEot) conclude(ST_NO_TRAFFIC, 0);
				else if (b == ChAck) conclude(ST_OK, 0);
				else if (b == ChNak) conclude(ST_NAK, 0);
				else if (b == ChStx) begin
					check_acc  = '0;
					nbytes     = 0;
					addr_match = 1'b0;
					phase      = PH_POLL_ADDR;
				end else conclude(ST_UNEXPECTED, 0);
			end
			PH_POLL_ADDR: begin
				check_acc ^= b;
				if (b == ChEtx) begin
					addr_match = 1'b0;
					phase      = PH_POLL_CHECK;
				end else begin
					addr_match = (b == PollBase + slave_q);
					phase      = PH_POLL_BODY;
				end
			end
			PH_POLL_BODY: begin
				if (b == ChEtx) begin
					check_acc ^= b;
					phase = PH_POLL_CHECK;
				end else if (nbytes + 2 >= frame_limit()) begin
					send_byte(ChEot);
					conclude(ST_MALFORMED, pay);
				end else begin
					check_acc ^= b;
					nbytes++;
					emit(KIND_PAYLOAD, b, ST_OK, 0);
				end
			end
			PH_POLL_CHECK: begin
				if (!addr_match) begin
					send_byte(ChEot);
					conclude(ST_WRONG_SLAVE, pay);
				end else if (b == (check_acc | CheckBit)) begin
					send_byte(ChAck);
					phase = PH_POLL_EOT;
				end else begin
					send_byte(ChEot);
					conclude(ST_CHECK_FAIL, pay);
				end
			end
			PH_POLL_EOT: conclude((b == ChEot) ? ST_OK : ST_NO_EOT, pay);
			PH_SEL_REPLY: begin
				if (b == ChAck) begin
					check_acc = SelBase + slave_q;
					nbytes    = 0;
					send_byte(ChStx);
					send_byte(check_acc);
					phase = PH_SEL_SEND;
				end else if (b == ChNak) conclude(ST_REFUSED, 0);
				else if (b == ChEot) conclude(ST_BUSY, 0);
				else if (b == ChStx) phase = PH_SEL_DRAIN;
				else conclude(ST_UNEXPECTED, 0);
			end
			PH_SEL_DRAIN: if (b == ChEtx) conclude(ST_UNEXPECTED, 0);
			PH_SEL_FINAL: begin
				if (b == ChAck) conclude(ST_OK, 0);
				else if (b == ChNak) conclude(ST_REFUSED, 0);
				else if (b == ChEot) conclude(ST_BUSY, 0);
				else conclude(ST_UNEXPECTED, 0);
			end
			default: ;
			endcase
		endfunction

		function void on_tick();
			if (phase == PH_IDLE || phase == PH_SEL_SEND) return;
			if (quiet_ticks < 16'hFFFF) quiet_ticks++;
			if (quiet_ticks < tick_limit()) return;
			case (phase)
			PH_POLL_REPLY: conclude(ST_TIMEOUT, 0);
			PH_POLL_ADDR, PH_POLL_BODY, PH_POLL_CHECK: begin
				send_byte(ChEot);
				conclude(ST_MALFORMED, nbytes);
			end
			PH_POLL_EOT: conclude(ST_TIMEOUT, nbytes);
			default: conclude(ST_UNEXPECTED, 0);
			endcase
		endfunction

		// Works out the results of one accepted item and queues them.
		function int predict_item(logic [2:0] cmd, logic [4:0] sl, logic [7:0] b, logic fin);
			batch.delete();
			case (cmd)
			CMD_POLL, CMD_SELECT: begin
				if (phase != PH_IDLE) emit(KIND_STATUS, 8'h00, ST_BAD_COMMAND, 0);
				else begin
					slave_q     = sl;
					quiet_ticks = 0;
					nbytes      = 0;
					send_byte(ChEnq);
					send_byte(((cmd == CMD_POLL) ? PollBase : SelBase) + sl);
					phase = (cmd == CMD_POLL) ? PH_POLL_REPLY : PH_SEL_REPLY;
				end
			end
			CMD_RX: on_rx(b);
			CMD_BYTE: begin
				if (phase != PH_SEL_SEND) emit(KIND_STATUS, 8'h00, ST_BAD_COMMAND, 0);
				else if (nbytes + 5 >= frame_limit()) conclude(ST_BAD_COMMAND, 0);
				else begin
					nbytes++;
					check_acc ^= b;
					send_byte(b);
					if (fin) begin
						send_byte(ChEtx);
						send_byte(check_acc ^ ChEtx ^ CheckBit);
						quiet_ticks = 0;
						phase = PH_SEL_FINAL;
					end
				end
			end
			CMD_TICK: on_tick();
			default: ;
			endcase
			if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
			foreach (batch[i]) awaited.push_back(batch[i]);
			return batch.size();
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [1:0] k, logic [7:0] b, logic [3:0] st,
				logic [12:0] len, logic lst);
			link_result_t want;
			if (awaited.size() == 0) begin
				$error("result with nothing awaited: kind %0d byte %0d status %0d length %0d",
					k, b, st, len);
				errors++;
				return;
			end
			want = awaited.pop_front();
			compare_field("kind", 16'(want.kind), 16'(k));
			compare_field("out_byte", 16'(want.data), 16'(b));
			compare_field("status", 16'(want.status), 16'(st));
			compare_field("length", 16'(want.length), 16'(len));
			compare_field("last", 16'(want.last), 16'(lst));
		endfunction
	endclass

	link_scoreboard board;
	bit s_fast;
	bit m_fast;
	int counted;

	// Register settings for the random part: out-of-range low values that
	// clamp, the largest values, and small limits so that timeouts and
	// oversize frames are actually reachable.
	int unsigned timeout_plan[6] = '{0, 3, 65535, 2, 5, 1};
	int unsigned length_plan[6]  = '{0, 8, 8191, 6, 12, 3};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Drives one item and waits for the handshake. The valid line is only
	// lowered when a gap is drawn, so back-to-back items keep it high.
	task automatic send_item(input logic [2:0] cmd, input logic [4:0] sl,
			input logic [7:0] b, input logic fin);
		int gap;
		gap = s_fast ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {3'b000, b, sl};
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		void'(board.predict_item(cmd, sl, b, fin));
		counted++;
		if ($urandom_range(0, 29) == 0) s_fast = ~s_fast;
	endtask

	// A received link byte; the unused fields carry random values.
	task automatic rx(input logic [7:0] b);
		send_item(CMD_RX, 5'($urandom), b, 1'($urandom));
	endtask

	// Now and then a few ticks, enough to reach the timeout when it is short.
	task automatic maybe_ticks();
		int n;
		if ($urandom_range(0, 7) != 0) return;
		n = (board.tick_limit() <= 8) ? $urandom_range(1, board.tick_limit())
			: $urandom_range(1, 4);
		repeat (n) send_item(CMD_TICK, 5'($urandom), 8'($urandom), 1'($urandom));
	endtask

	// Poll exchange: mostly a correct reply frame with random payload, at
	// times a short answer, a wrong address, a bad check byte, an oversize
	// frame, a missing EOT or a timeout somewhere along the way.
	task automatic run_poll();
		logic [4:0] sl;
		logic [7:0] addr;
		logic [7:0] chk;
		logic [7:0] b;
		int lim;
		int len;
		int pick;
		sl = 5'($urandom_range(0, 31));
		send_item(CMD_POLL, sl, 8'($urandom), 1'($urandom));
		maybe_ticks();
		if (board.phase != PH_POLL_REPLY) return;
		pick = $urandom_range(0, 9);
		if (pick == 0) rx(ChEot);
		else if (pick == 1) rx(ChAck);
		else if (pick == 2) rx(ChNak);
		else if (pick == 3) rx(8'($urandom));
		if (pick <= 3) return;
		rx(ChStx);
		maybe_ticks();
		if (board.phase != PH_POLL_ADDR) return;
		pick = $urandom_range(0, 9);
		addr = (pick < 7) ? PollBase + sl : (pick == 7) ? ChEtx : 8'($urandom);
		rx(addr);
		chk = addr;
		if (addr != ChEtx) begin
			lim = board.frame_limit();
			if (lim <= 16 && $urandom_range(0, 4) == 0)
				len = lim - 1;
			else
				len = $urandom_range(0, (lim - 2 < 6) ? lim - 2 : 6);
			for (int i = 0; i < len; i++) begin
				if (board.phase != PH_POLL_BODY) return;
				b = 8'($urandom);
				rx(b);
				chk ^= b;
				maybe_ticks();
			end
			if (board.phase != PH_POLL_BODY) return;
			rx(ChEtx);
			chk ^= ChEtx;
		end
		maybe_ticks();
		if (board.phase != PH_POLL_CHECK) return;
		rx(($urandom_range(0, 4) == 0) ? 8'($urandom) : (chk | CheckBit));
		maybe_ticks();
		if (board.phase != PH_POLL_EOT) return;
		rx(($urandom_range(0, 4) == 0) ? 8'($urandom) : ChEot);
	endtask

	// Select exchange: mostly accepted and followed by a command of random
	// bytes, with stray items mixed in; at times refused, busy, answered by
	// a frame that has to be drained, or a command one byte too long.
	task automatic run_select();
		logic [4:0] sl;
		int lim;
		int n;
		int pick;
		sl = 5'($urandom_range(0, 31));
		send_item(CMD_SELECT, sl, 8'($urandom), 1'($urandom));
		maybe_ticks();
		if (board.phase != PH_SEL_REPLY) return;
		pick = $urandom_range(0, 9);
		if (pick == 0) rx(ChNak);
		else if (pick == 1) rx(ChEot);
		else if (pick == 2) rx(8'($urandom));
		else if (pick == 3) begin
			rx(ChStx);
			repeat ($urandom_range(0, 3)) begin
				if (board.phase == PH_SEL_DRAIN) rx(8'($urandom));
				maybe_ticks();
			end
			if (board.phase == PH_SEL_DRAIN) rx(ChEtx);
		end
		if (pick <= 3) return;
		rx(ChAck);
		lim = board.frame_limit();
		if (lim <= 16 && $urandom_range(0, 4) == 0)
			n = (lim - 4 < 1) ? 1 : lim - 4;
		else
			n = $urandom_range(1, (lim - 5 < 1) ? 1 : (lim - 5 > 6) ? 6 : lim - 5);
		for (int i = 0; i < n; i++) begin
			if (board.phase != PH_SEL_SEND) return;
			if ($urandom_range(0, 9) == 0) begin
				// Stray items: ticks and link bytes are ignored here, a
				// start is refused without touching the exchange.
				case ($urandom_range(0, 2))
				0: send_item(CMD_TICK, 5'($urandom), 8'($urandom), 1'($urandom));
				1: rx(8'($urandom));
				default: send_item(CMD_POLL, 5'($urandom), 8'($urandom), 1'($urandom));
				endcase
			end
			send_item(CMD_BYTE, 5'($urandom), 8'($urandom), i == n - 1);
		end
		maybe_ticks();
		if (board.phase != PH_SEL_FINAL) return;
		pick = $urandom_range(0, 9);
		if (pick < 6) rx(ChAck);
		else if (pick == 6) rx(ChNak);
		else if (pick == 7) rx(ChEot);
		else rx(8'($urandom));
	endtask

	// Brings the link back to idle with the shortest path from each phase.
	task automatic finish_exchange();
		while (board.phase != PH_IDLE) begin
			case (board.phase)
			PH_SEL_SEND: send_item(CMD_BYTE, 5'($urandom), 8'($urandom), 1'b1);
			PH_SEL_DRAIN, PH_POLL_ADDR, PH_POLL_BODY: rx(ChEtx);
			default: rx(ChEot);
			endcase
		end
	endtask

	// Stops sending and waits until every awaited result has come, then
	// lets items that cause no result run out of the pipeline.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (board.awaited.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Writes the timeout register, then the length register; only legal while idle.
	task automatic configure(input logic [15:0] ticks, input logic [12:0] max_len);
		cfg_wen   <= 1'b1;
		cfg_index <= CFG_TIMEOUT;
		cfg_wdata <= ticks;
		@(posedge clk);
		board.write_reg(CFG_TIMEOUT, ticks);
		cfg_index <= CFG_MAX_LENGTH;
		cfg_wdata <= {3'b000, max_len};
		@(posedge clk);
		board.write_reg(CFG_MAX_LENGTH, {3'b000, max_len});
		cfg_wen <= 1'b0;
	endtask

	// Result side: a random stall before each result, with runs of none.
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			int stall;
			stall = m_fast ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			board.check_result(m_tuser, m_tdata[7:0], m_tdata[11:8], m_tdata[24:12], m_tlast);
			if ($urandom_range(0, 29) == 0) m_fast = ~m_fast;
		end
	end

	// Ends the run if no item moves on either side for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < WatchdogLimit) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int pick;
		board     = new();
		s_fast    = 1'b0;
		m_fast    = 1'b0;
		counted   = 0;
		arst_n    <= 1'b0;
		cfg_wen   <= 1'b0;
		cfg_index <= CFG_TIMEOUT;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= CMD_TICK;
		s_tlast   <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset register values. Bytes and reserved
		// commands while idle are ignored; a command byte while idle and a
		// second start are refused without changing anything.
		rx(ChAck);
		send_item(CmdReserved, 5'd31, 8'hFF, 1'b1);
		send_item(CMD_BYTE, 5'd0, 8'h00, 1'b0);
		// Poll of the highest slave with a good frame carrying both byte
		// extremes, acknowledged and closed by the slave's EOT.
		send_item(CMD_POLL, 5'd31, 8'h00, 1'b0);
		send_item(CMD_SELECT, 5'd0, 8'h00, 1'b0);
		rx(ChStx);
		rx(PollBase + 5'd31);
		rx(8'hFF);
		rx(8'h00);
		rx(ChEtx);
		rx(((PollBase + 5'd31) ^ 8'hFF ^ 8'h00 ^ ChEtx) | CheckBit);
		rx(ChEot);
		// ETX where the echoed address belongs: judged as a wrong slave.
		send_item(CMD_POLL, 5'd1, 8'h00, 1'b0);
		rx(ChStx);
		rx(ChEtx);
		rx(8'hFF);
		// Select of slave 0 with a two-byte command, accepted by the slave.
		send_item(CMD_SELECT, 5'd0, 8'h00, 1'b0);
		rx(ChAck);
		send_item(CMD_BYTE, 5'd0, 8'h00, 1'b0);
		send_item(CMD_BYTE, 5'd31, 8'hFF, 1'b1);
		rx(ChAck);
		// Select answered by a frame: bytes are dropped until its ETX.
		send_item(CMD_SELECT, 5'd31, 8'hFF, 1'b1);
		rx(ChStx);
		rx(8'h55);
		rx(ChEtx);
		settle();

		// Random part: one block of exchanges per register setting, each
		// started and ended with the link idle and the result stream drained.
		for (int p = 0; p < 6; p++) begin
			configure(16'(timeout_plan[p]), 13'(length_plan[p]));
			counted = 0;
			while (counted < ItemsPerSetting) begin
				pick = $urandom_range(0, 9);
				if (pick < 4)
					run_poll();
				else if (pick < 8)
					run_select();
				else
					repeat ($urandom_range(1, 3))
						send_item(3'($urandom_range(0, 7)), 5'($urandom),
							8'($urandom), 1'($urandom));
				finish_exchange();
			end
			settle();
		end

		if (board.errors == 0 && board.awaited.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
